FILE: rtl/teq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the timed event queue
// Transfer payloads, action codes, controller states and sizing defaults.
// ----------------------------------------------------------------------------
package teq_pkg;

  // Sizing
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int EVENT_BITS      = 4;
  localparam int TIME_BITS       = 16;
  localparam int BUMP_STEP       = 64;
  localparam int BUMP_LOG        = $clog2(BUMP_STEP);

  // Action codes
  typedef enum logic [1:0] {
    ACT_ADD        = 2'd0,
    ACT_ADD_ABSENT = 2'd1,
    ACT_PULL       = 2'd2,
    ACT_QUERY      = 2'd3
  } teq_action_t;

  // Command transfer
  typedef struct packed {
    teq_action_t            action;
    logic [EVENT_BITS-1:0]  event_type;
    logic [TIME_BITS-1:0]   delay;
    logic [TIME_BITS-1:0]   now;
  } teq_cmd_t;

  // Response transfer
  typedef struct packed {
    logic [EVENT_BITS-1:0]  pulled_event;
    logic                   found;
    logic                   overflow;
    logic [TIME_BITS-1:0]   due_time;
  } teq_rsp_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD_START,
    ST_LOC_FIRST,
    ST_LOC_WALK,
    ST_PLACE,
    ST_BUMP,
    ST_SHIFT,
    ST_WRITE,
    ST_PULL_CHK,
    ST_DONE
  } teq_state_t;

  // How an add lands in the ring
  typedef enum logic [1:0] {
    PM_FIRST,
    PM_APPEND,
    PM_PREPEND,
    PM_MIDDLE
  } teq_place_t;

endpackage
`default_nettype wire

FILE: rtl/teq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/timed_event_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_queue: sorted ring of timed events
// Events (due time, type) held in two RAMs, ordered by due time relative to a
// wrapping current time. Add, add-if-absent, pull-if-due and query.
//
//   channel  dir   handshake            payload
//   cmd      in    cmd_valid/cmd_stall  teq_cmd_t (action, event_type, delay, now)
//   rsp      out   rsp_valid/rsp_stall  teq_rsp_t (pulled_event, found, overflow,
//                                                  due_time)
//
// One command at a time; one RAM entry is visited per cycle over the single
// read port. Add walks to its slot, steps past entries with an equal time
// and shifts later entries tailward; add-if-absent runs the query scan first.
// Reset clears pointers, count and per-entry valid bits at once; entries not
// yet written read as zero. A new command is taken while a response still
// waits under rsp_stall; the next response waits in its last state.
// ----------------------------------------------------------------------------
module timed_event_queue #(
  parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire teq_pkg::teq_cmd_t cmd,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output teq_pkg::teq_rsp_t      rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = teq_pkg::TIME_BITS;
  localparam int EW    = teq_pkg::EVENT_BITS;
  localparam int BL    = teq_pkg::BUMP_LOG;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // Control registers
  teq_pkg::teq_state_t state, state_next;
  teq_pkg::teq_place_t mode, mode_next;
  logic [IDX_W-1:0]    head, head_next, tail, tail_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [QUEUE_DEPTH-1:0] valid;
  logic                rd_valid;
  logic                rsp_load;

  // Working registers
  logic [IDX_W-1:0]    pos, pos_next, dst, dst_next;
  logic [CNT_W-1:0]    scan_cnt, scan_cnt_next;
  logic [TW-1:0]       t_due, t_due_next;
  logic [TW-1:0]       now_q;
  logic [EW-1:0]       kind_q;
  teq_pkg::teq_action_t act_q;
  logic                wrap_q, wrap_next;
  logic [EW-1:0]       res_pulled, res_pulled_next;
  logic                res_found, res_found_next;
  logic                res_ovf, res_ovf_next;
  logic [TW-1:0]       res_due, res_due_next;

  // RAM ports
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic                due_we, kind_we;
  logic [TW-1:0]       due_wdata, due_rdata, due_cur;
  logic [EW-1:0]       kind_wdata, kind_rdata, kind_cur;

  // Derived values
  logic [IDX_W-1:0]    after_tail, before_head, walk_pos, stop_pos, first_pos;
  logic [IDX_W-1:0]    src;
  logic [TW-1:0]       sum, bumped;
  logic                walk_go, first_exit;

  teq_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (wr_addr),
    .wdata (due_wdata),
    .raddr (rd_addr),
    .rdata (due_rdata)
  );

  teq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_kind_ram (
    .clk   (clk),
    .we    (kind_we),
    .waddr (wr_addr),
    .wdata (kind_wdata),
    .raddr (rd_addr),
    .rdata (kind_rdata)
  );

  // Entries never written read as zero
  assign due_cur  = rd_valid ? due_rdata  : '0;
  assign kind_cur = rd_valid ? kind_rdata : '0;

  assign after_tail  = idx_inc(tail);
  assign before_head = idx_dec(head);
  assign src         = idx_dec(dst);

  // Due time of a new add, nudged off multiples of the bump step
  assign sum    = cmd.now + cmd.delay;
  assign bumped = (sum[BL-1:0] == '0) ? sum + 1'b1 : sum;

  // Slot walk: toward the head when wrapped, toward the tail otherwise
  always_comb begin
    if (wrap_q) begin
      walk_go    = (due_cur >= t_due) && (due_cur < now_q) && (pos != before_head);
      walk_pos   = idx_dec(pos);
      stop_pos   = (pos != before_head) ? idx_inc(pos) : pos;
      first_exit = (due_cur >= now_q) || (t_due > due_cur);
      first_pos  = after_tail;
    end else begin
      walk_go    = (due_cur < t_due) && (due_cur >= now_q) && (pos != after_tail);
      walk_pos   = idx_inc(pos);
      stop_pos   = pos;
      first_exit = (due_cur < now_q) || (due_cur > t_due);
      first_pos  = before_head;
    end
  end

  assign cmd_stall = (state != teq_pkg::ST_IDLE);
  assign rsp_load  = (state == teq_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    pos_next        = pos;
    dst_next        = dst;
    scan_cnt_next   = scan_cnt;
    t_due_next      = t_due;
    wrap_next       = wrap_q;
    res_pulled_next = res_pulled;
    res_found_next  = res_found;
    res_ovf_next    = res_ovf;
    res_due_next    = res_due;
    rd_addr         = pos;
    wr_addr         = pos;
    due_we          = 1'b0;
    kind_we         = 1'b0;
    due_wdata       = t_due;
    kind_wdata      = kind_q;

    unique case (state)
      teq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          t_due_next      = bumped;
          res_pulled_next = '0;
          res_found_next  = 1'b0;
          res_ovf_next    = 1'b0;
          res_due_next    = '0;
          pos_next        = head;
          scan_cnt_next   = '0;
          rd_addr         = head;
          unique case (cmd.action)
            teq_pkg::ACT_ADD: begin
              state_next = teq_pkg::ST_ADD_START;
            end
            teq_pkg::ACT_ADD_ABSENT: begin
              state_next = (count == '0) ? teq_pkg::ST_ADD_START : teq_pkg::ST_SCAN;
            end
            teq_pkg::ACT_QUERY: begin
              state_next = (count == '0) ? teq_pkg::ST_DONE : teq_pkg::ST_SCAN;
            end
            teq_pkg::ACT_PULL: begin
              state_next = (count == '0) ? teq_pkg::ST_DONE : teq_pkg::ST_PULL_CHK;
            end
            default: state_next = teq_pkg::ST_IDLE;
          endcase
        end
      end

      // Presence scan over head..tail
      teq_pkg::ST_SCAN: begin
        if (kind_cur == kind_q) begin
          res_found_next = 1'b1;
          state_next     = teq_pkg::ST_DONE;
        end else if (scan_cnt == count - 1'b1) begin
          state_next = (act_q == teq_pkg::ACT_QUERY) ? teq_pkg::ST_DONE
                                                     : teq_pkg::ST_ADD_START;
        end else begin
          pos_next      = idx_inc(pos);
          rd_addr       = idx_inc(pos);
          scan_cnt_next = scan_cnt + 1'b1;
        end
      end

      teq_pkg::ST_ADD_START: begin
        if (count == '0) begin
          mode_next  = teq_pkg::PM_FIRST;
          pos_next   = head;
          state_next = teq_pkg::ST_WRITE;
        end else if (count >= FULL_CNT) begin
          res_ovf_next = 1'b1;
          state_next   = teq_pkg::ST_DONE;
        end else begin
          wrap_next  = (t_due < now_q);
          pos_next   = (t_due < now_q) ? tail : head;
          rd_addr    = (t_due < now_q) ? tail : head;
          state_next = teq_pkg::ST_LOC_FIRST;
        end
      end

      teq_pkg::ST_LOC_FIRST, teq_pkg::ST_LOC_WALK: begin
        if ((state == teq_pkg::ST_LOC_FIRST) && first_exit) begin
          pos_next   = first_pos;
          state_next = teq_pkg::ST_PLACE;
        end else if (walk_go) begin
          pos_next   = walk_pos;
          rd_addr    = walk_pos;
          state_next = teq_pkg::ST_LOC_WALK;
        end else begin
          pos_next   = stop_pos;
          state_next = teq_pkg::ST_PLACE;
        end
      end

      teq_pkg::ST_PLACE: begin
        if (pos == after_tail) begin
          mode_next  = teq_pkg::PM_APPEND;
          state_next = teq_pkg::ST_WRITE;
        end else if (pos == before_head) begin
          mode_next  = teq_pkg::PM_PREPEND;
          state_next = teq_pkg::ST_WRITE;
        end else begin
          mode_next  = teq_pkg::PM_MIDDLE;
          rd_addr    = pos;
          state_next = teq_pkg::ST_BUMP;
        end
      end

      // Step past entries with an equal time
      teq_pkg::ST_BUMP: begin
        if (pos == after_tail) begin
          mode_next  = teq_pkg::PM_APPEND;
          state_next = teq_pkg::ST_WRITE;
        end else if (due_cur == t_due) begin
          pos_next   = idx_inc(pos);
          rd_addr    = idx_inc(pos);
          t_due_next = t_due + 1'b1;
        end else begin
          dst_next   = after_tail;
          rd_addr    = tail;
          state_next = teq_pkg::ST_SHIFT;
        end
      end

      // Move one entry tailward per cycle
      teq_pkg::ST_SHIFT: begin
        due_we     = 1'b1;
        kind_we    = 1'b1;
        wr_addr    = dst;
        due_wdata  = due_cur;
        kind_wdata = kind_cur;
        dst_next   = src;
        rd_addr    = idx_dec(src);
        if (src == pos) begin
          state_next = teq_pkg::ST_WRITE;
        end
      end

      teq_pkg::ST_WRITE: begin
        due_we       = 1'b1;
        kind_we      = 1'b1;
        count_next   = count + 1'b1;
        res_due_next = t_due;
        unique case (mode)
          teq_pkg::PM_APPEND, teq_pkg::PM_MIDDLE: tail_next = after_tail;
          teq_pkg::PM_PREPEND:                    head_next = before_head;
          default:                                head_next = head;
        endcase
        state_next = teq_pkg::ST_DONE;
      end

      teq_pkg::ST_PULL_CHK: begin
        if (due_cur == now_q) begin
          res_pulled_next = kind_cur;
          kind_we         = 1'b1;
          wr_addr         = head;
          kind_wdata      = '0;
          count_next      = count - 1'b1;
          if (head != tail) begin
            head_next = idx_inc(head);
          end
        end
        state_next = teq_pkg::ST_DONE;
      end

      teq_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_next = teq_pkg::ST_IDLE;
        end
      end

      default: state_next = teq_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= teq_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      valid     <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      rd_valid <= valid[rd_addr];
      if (due_we || kind_we) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    mode       <= mode_next;
    pos        <= pos_next;
    dst        <= dst_next;
    scan_cnt   <= scan_cnt_next;
    t_due      <= t_due_next;
    wrap_q     <= wrap_next;
    res_pulled <= res_pulled_next;
    res_found  <= res_found_next;
    res_ovf    <= res_ovf_next;
    res_due    <= res_due_next;
    if (state == teq_pkg::ST_IDLE && cmd_valid) begin
      now_q  <= cmd.now;
      kind_q <= cmd.event_type;
      act_q  <= cmd.action;
    end
    if (rsp_load) begin
      rsp.pulled_event <= res_pulled;
      rsp.found        <= res_found;
      rsp.overflow     <= res_ovf;
      rsp.due_time     <= res_due;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == teq_pkg::ST_DONE && !rsp_valid) |=> rsp_valid)
    else $error("finished command did not reach the response register");

  a_empty_pull: assert property (@(posedge clk) disable iff (rst)
    (state == teq_pkg::ST_IDLE && cmd_valid && cmd.action == teq_pkg::ACT_PULL
     && count == '0) |=> (state == teq_pkg::ST_DONE))
    else $error("pull on empty queue did not finish at once");

  a_ovf_no_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.overflow && rsp.due_time != '0))
    else $error("rejected add reports a stored time");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the timed event queue
// Drives a directed table and then random add/pull/query commands with random
// idle bursts on both channels; every response is compared with a behavioral
// model of the sorted ring kept inside this bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH      = teq_pkg::QUEUE_DEPTH_DEF;
  localparam int N_RANDOM   = 700;
  localparam int IDLE_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  teq_pkg::teq_cmd_t cmd;
  logic              rsp_valid;
  logic              rsp_stall;
  teq_pkg::teq_rsp_t rsp;

  timed_event_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Model state
  logic [15:0] ring_due [DEPTH];
  logic [3:0]  ring_kind[DEPTH];
  int unsigned ring_head, ring_tail, ring_count;

  teq_pkg::teq_rsp_t pending_rsp[$];
  int       fail_count;
  int       idle_cycles;
  bit       quiet_phase;
  int       rsp_pause;

  function automatic int unsigned nxt(int unsigned i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int unsigned prv(int unsigned i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  function automatic bit kind_queued(logic [3:0] k);
    int unsigned i;
    int n;
    i = ring_head;
    if (ring_count == 0) return 0;
    if (ring_count == 1) return ring_kind[ring_head] == k;
    for (n = 0; n < DEPTH && i != ring_tail && ring_kind[i] != k; n++) i = nxt(i);
    return (i != ring_tail) || (ring_kind[i] == k);
  endfunction

  function automatic int unsigned find_slot(logic [15:0] t, logic [15:0] now_t);
    int unsigned pos, endp;
    logic [15:0] cur;
    int n;
    if (t < now_t) begin
      pos = ring_tail;
      cur = ring_due[pos];
      if (cur >= now_t || t > cur) return nxt(pos);
      endp = (ring_tail + DEPTH - (ring_count % DEPTH)) % DEPTH;
      for (n = 0; n <= DEPTH && cur >= t && cur < now_t && pos != endp; n++) begin
        pos = prv(pos);
        cur = ring_due[pos];
      end
      if (pos != endp) pos = nxt(pos);
      return pos;
    end
    pos = ring_head;
    cur = ring_due[pos];
    if (cur < now_t || cur > t) return prv(pos);
    endp = (ring_head + ring_count) % DEPTH;
    for (n = 0; n <= DEPTH && cur < t && cur >= now_t && pos != endp; n++) begin
      pos = nxt(pos);
      cur = ring_due[pos];
    end
    return pos;
  endfunction

  // Insert into the sorted ring; returns 0 when the ring is full
  function automatic bit insert_event(logic [3:0] k, logic [15:0] dly, logic [15:0] now_t,
                                      output logic [15:0] stored);
    logic [15:0] t;
    int unsigned pos, bh, at, dst;
    int n;
    t = now_t + dly;
    stored = '0;
    if (t[5:0] == 6'd0) t = t + 16'd1;
    if (ring_count == 0) begin
      ring_due[ring_head]  = t;
      ring_kind[ring_head] = k;
      ring_count = 1;
      stored = t;
      return 1;
    end
    if (ring_count >= DEPTH - 1) return 0;
    pos = find_slot(t, now_t);
    bh = prv(ring_head);
    at = nxt(ring_tail);
    if (pos == at) begin
      ring_tail = at;
    end else if (pos == bh) begin
      ring_head = bh;
    end else begin
      // bump past entries with the same time
      for (n = 0; n < DEPTH && ring_due[pos] == t && pos != at; n++) begin
        pos = nxt(pos);
        t = t + 16'd1;
      end
      if (pos != at) begin
        dst = at;
        for (n = 0; n < DEPTH && dst != pos; n++) begin
          ring_due[dst]  = ring_due[prv(dst)];
          ring_kind[dst] = ring_kind[prv(dst)];
          dst = prv(dst);
        end
      end
      ring_tail = at;
    end
    ring_due[pos]  = t;
    ring_kind[pos] = k;
    ring_count++;
    stored = t;
    return 1;
  endfunction

  function automatic teq_pkg::teq_rsp_t queue_response(teq_pkg::teq_cmd_t c);
    teq_pkg::teq_rsp_t r;
    logic [15:0] st;
    r = '0;
    case (c.action)
      teq_pkg::ACT_ADD, teq_pkg::ACT_ADD_ABSENT: begin
        if (c.action == teq_pkg::ACT_ADD_ABSENT && kind_queued(c.event_type)) begin
          r.found = 1'b1;
        end else if (insert_event(c.event_type, c.delay, c.now, st)) begin
          r.due_time = st;
        end else begin
          r.overflow = 1'b1;
        end
      end
      teq_pkg::ACT_PULL: begin
        if (ring_count > 0 && ring_due[ring_head] == c.now) begin
          r.pulled_event = ring_kind[ring_head];
          ring_kind[ring_head] = '0;
          if (ring_head != ring_tail) ring_head = nxt(ring_head);
          ring_count--;
        end
      end
      default: r.found = kind_queued(c.event_type);
    endcase
    return r;
  endfunction

  // Directed table: command plus optional hand-written response
  typedef struct {
    teq_pkg::teq_cmd_t c;
    bit                fixed;
    teq_pkg::teq_rsp_t r;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic teq_pkg::teq_cmd_t mk(teq_pkg::teq_action_t a, logic [3:0] k,
                                           logic [15:0] d, logic [15:0] n);
    teq_pkg::teq_cmd_t c;
    c.action = a; c.event_type = k; c.delay = d; c.now = n;
    return c;
  endfunction

  function automatic teq_pkg::teq_rsp_t rs(logic [3:0] p, logic f, logic o, logic [15:0] d);
    teq_pkg::teq_rsp_t r;
    r.pulled_event = p; r.found = f; r.overflow = o; r.due_time = d;
    return r;
  endfunction

  task automatic add_row(teq_pkg::teq_cmd_t c, bit fixed = 0, teq_pkg::teq_rsp_t r = '0);
    dir_row_t row;
    row.c = c; row.fixed = fixed; row.r = r;
    dir_rows.push_back(row);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response checker and receiver stall
  always @(posedge clk) begin
    teq_pkg::teq_rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing expected: %p", rsp);
        fail_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.pulled_event !== exp_rsp.pulled_event) begin
          $error("pulled_event expected %0d got %0d", exp_rsp.pulled_event, rsp.pulled_event);
          fail_count++;
        end
        if (rsp.found !== exp_rsp.found) begin
          $error("found expected %0b got %0b", exp_rsp.found, rsp.found);
          fail_count++;
        end
        if (rsp.overflow !== exp_rsp.overflow) begin
          $error("overflow expected %0b got %0b", exp_rsp.overflow, rsp.overflow);
          fail_count++;
        end
        if (rsp.due_time !== exp_rsp.due_time) begin
          $error("due_time expected %0d got %0d", exp_rsp.due_time, rsp.due_time);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || quiet_phase) begin
      rsp_stall <= 1'b0;
      rsp_pause <= 0;
    end else if (rsp_pause > 0) begin
      rsp_stall <= 1'b1;
      rsp_pause <= rsp_pause - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      rsp_pause <= $urandom_range(0, 13);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Hold cmd until accepted; predict at the accepting edge
  task automatic send_cmd(teq_pkg::teq_cmd_t c, bit fixed, teq_pkg::teq_rsp_t r);
    teq_pkg::teq_rsp_t p;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    p = queue_response(c);
    if (fixed && p != r) begin
      $error("directed row disagrees: expected %p model %p", r, p);
      fail_count++;
    end
    pending_rsp.push_back(fixed ? r : p);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  function automatic teq_pkg::teq_cmd_t random_cmd(logic [15:0] now_t);
    teq_pkg::teq_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.event_type = 4'($urandom_range(0, 15));
    c.now = now_t;
    if (sel < 45) begin
      c.action = ($urandom_range(0, 3) == 0) ? teq_pkg::ACT_ADD_ABSENT : teq_pkg::ACT_ADD;
      case ($urandom_range(0, 3))
        0: c.delay = 16'($urandom_range(0, 8));
        1: c.delay = 16'($urandom_range(0, 300));
        2: c.delay = 16'(64 * $urandom_range(0, 4) - c.now[5:0]);
        default: c.delay = 16'($urandom);
      endcase
    end else if (sel < 80) begin
      c.action = teq_pkg::ACT_PULL;
      c.delay = 16'($urandom);
    end else begin
      c.action = teq_pkg::ACT_QUERY;
      c.delay = 16'($urandom);
    end
    return c;
  endfunction

  initial begin
    teq_pkg::teq_cmd_t c;
    logic [15:0] now_t;
    int i;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    fail_count = 0;
    quiet_phase = 0;
    for (i = 0; i < DEPTH; i++) begin
      ring_due[i] = '0;
      ring_kind[i] = '0;
    end
    ring_head = 0; ring_tail = 0; ring_count = 0;

    // Directed: empty checks, extremes, equal-time bumps, full ring, wrap
    add_row(mk(teq_pkg::ACT_PULL, 4'd0, 16'd0, 16'd0), 1, rs(0, 0, 0, 0));
    add_row(mk(teq_pkg::ACT_QUERY, 4'd0, 16'd0, 16'd0), 1, rs(0, 0, 0, 0));
    add_row(mk(teq_pkg::ACT_ADD, 4'd15, 16'hFFFF, 16'hFFFF), 1, rs(0, 0, 0, 16'hFFFE));
    add_row(mk(teq_pkg::ACT_QUERY, 4'd15, 16'd0, 16'd0), 1, rs(0, 1, 0, 0));
    add_row(mk(teq_pkg::ACT_ADD_ABSENT, 4'd15, 16'd5, 16'd0), 1, rs(0, 1, 0, 0));
    add_row(mk(teq_pkg::ACT_ADD, 4'd1, 16'd0, 16'd0));
    add_row(mk(teq_pkg::ACT_ADD, 4'd2, 16'd10, 16'd0));
    add_row(mk(teq_pkg::ACT_ADD, 4'd3, 16'd10, 16'd0));
    add_row(mk(teq_pkg::ACT_ADD, 4'd4, 16'd10, 16'd0));
    add_row(mk(teq_pkg::ACT_ADD_ABSENT, 4'd0, 16'd100, 16'd0));
    add_row(mk(teq_pkg::ACT_QUERY, 4'd0, 16'd0, 16'd0));
    add_row(mk(teq_pkg::ACT_PULL, 4'd0, 16'd0, 16'd1));
    add_row(mk(teq_pkg::ACT_PULL, 4'd0, 16'd0, 16'd5));
    for (i = 0; i < 10; i++) add_row(mk(teq_pkg::ACT_ADD, 4'(i + 5), 16'(i * 37), 16'd1));
    add_row(mk(teq_pkg::ACT_ADD, 4'd9, 16'd1, 16'd1), 1, rs(0, 0, 1, 0));
    add_row(mk(teq_pkg::ACT_PULL, 4'd0, 16'd0, 16'hFFFE));

    // Hold off until reset is released
    while (rst) @(negedge clk);

    foreach (dir_rows[k]) begin
      send_cmd(dir_rows[k].c, dir_rows[k].fixed, dir_rows[k].r);
      idle_burst();
    end

    // Drain: pull everything by presenting each head time
    while (ring_count > 0) begin
      send_cmd(mk(teq_pkg::ACT_PULL, 4'd0, 16'd0, ring_due[ring_head]), 0, '0);
      idle_burst();
    end

    // Let every response land before the random part
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);

    // Random: time advances, pulls often hit the head
    now_t = 16'($urandom);
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) quiet_phase = 1;
      if ($urandom_range(0, 3) == 0) now_t = 16'(now_t + $urandom_range(0, 40));
      c = random_cmd(now_t);
      if (c.action == teq_pkg::ACT_PULL && ring_count > 0 && $urandom_range(0, 2) != 0) begin
        c.now = ring_due[ring_head];
        now_t = c.now;
      end
      send_cmd(c, 0, '0);
      idle_burst();
    end
    cmd_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hold reset, then release it on a falling clock edge
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule
